[hw/rtl/fbb_pkg.sv]
// ----------------------------------------------------------------------------
// fbb_pkg
// Shared constants, types and helpers of the foreground bounding box block.
// ----------------------------------------------------------------------------
`default_nettype none

package fbb_pkg;

	// coordinate range and derived widths
	localparam int COORD_LIMIT   = 4096;
	localparam int COORD_W       = $clog2(COORD_LIMIT);
	localparam int WIDTH_W       = COORD_W + 1;
	localparam int IMG_WIDTH_W   = 13;
	localparam int CH_W          = 8;
	localparam int TOL_W         = 8;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 16;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CH_W-1:0]    chan_t;

	localparam coord_t COORD_MAX = coord_t'(COORD_LIMIT - 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = CFG_IDX_W'(1);

	// register reset values
	localparam logic [TOL_W-1:0]       TOLERANCE_RESET = TOL_W'(10);
	localparam logic [IMG_WIDTH_W-1:0] WIDTH_RESET     = IMG_WIDTH_W'(640);

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	// settings seen by the datapath, width already folded into range
	typedef struct packed {
		logic [TOL_W-1:0]   tolerance;
		logic [WIDTH_W-1:0] width;
	} cfg_t;

	// true when the channels differ by more than the tolerance
	function automatic logic channel_differs(chan_t a, chan_t b, logic [TOL_W-1:0] tol);
		chan_t d;
		d = (a > b) ? (a - b) : (b - a);
		return d > tol;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/fbb_pixel_if.sv]
// ----------------------------------------------------------------------------
// fbb_pixel_if
// Pixel stream channel: one RGB pixel per word with an end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbb_pixel_if;
	logic                valid;
	logic                ready;
	fbb_pkg::chan_t      red;
	fbb_pkg::chan_t      green;
	fbb_pkg::chan_t      blue;
	logic                frame_last;

	modport source (output valid, red, green, blue, frame_last, input ready);
	modport sink   (input valid, red, green, blue, frame_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/fbb_box_if.sv]
// ----------------------------------------------------------------------------
// fbb_box_if
// Result channel: bounding box of one frame with a found flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbb_box_if;
	logic            valid;
	logic            ready;
	logic            found;
	fbb_pkg::coord_t min_x;
	fbb_pkg::coord_t max_x;
	fbb_pkg::coord_t min_y;
	fbb_pkg::coord_t max_y;

	modport source (output valid, found, min_x, max_x, min_y, max_y, input ready);
	modport sink   (input valid, found, min_x, max_x, min_y, max_y, output ready);
endinterface

`default_nettype wire

[hw/rtl/fbb_cfg_if.sv]
// ----------------------------------------------------------------------------
// fbb_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbb_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [fbb_pkg::CFG_IDX_W-1:0]       index;
	logic [fbb_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/fbb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fbb_cfg_regs
// Tolerance and image width registers; writes to unknown indexes are dropped.
// The width is folded into 1..COORD_LIMIT for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	fbb_cfg_if.sink           cfg,
	output fbb_pkg::cfg_t     settings
);

	logic [fbb_pkg::TOL_W-1:0]       tolerance_q;
	logic [fbb_pkg::IMG_WIDTH_W-1:0] image_width_q;
	logic                            width_wide;

	// always ready for a write
	assign cfg.ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q   <= fbb_pkg::TOLERANCE_RESET;
			image_width_q <= fbb_pkg::WIDTH_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				fbb_pkg::REG_TOLERANCE:   tolerance_q   <= cfg.data[fbb_pkg::TOL_W-1:0];
				fbb_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg.data[fbb_pkg::IMG_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// zero or oversize width acts as the full coordinate range
	assign width_wide = (32'(image_width_q) > 32'(fbb_pkg::COORD_LIMIT));

	always_comb begin
		settings.tolerance = tolerance_q;
		if (image_width_q == '0 || width_wide) begin
			settings.width = fbb_pkg::WIDTH_W'(fbb_pkg::COORD_LIMIT);
		end else begin
			settings.width = fbb_pkg::WIDTH_W'(image_width_q);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/foreground_bounding_box_core.sv]
// ----------------------------------------------------------------------------
// foreground_bounding_box_core
// Bounding box of the foreground in a raster-order RGB pixel stream. The first
// pixel of a frame is the background; the box is reported on the last pixel.
//
//  channel  dir  handshake     words
//  cfg      in   valid/ready   register index + data
//  pixel    in   valid/ready   red, green, blue, frame_last
//  box      out  valid/ready   found, min_x, max_x, min_y, max_y
//
//  one pixel per cycle sustained; stage 1 then result register to box
//  stage 1 holds the pixel, the frame state and box register update from it
//  a stalled box only holds up a frame_last pixel; other pixels keep flowing
//  pixel ready follows box ready combinationally through one gate
//  reset gives tolerance 10, width 640 and an empty frame
// ----------------------------------------------------------------------------
`default_nettype none

module foreground_bounding_box_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fbb_cfg_if.sink      cfg,
	fbb_pixel_if.sink    pixel,
	fbb_box_if.source    box
);

	fbb_pkg::cfg_t   settings;

	// input stage
	logic            valid_s1;
	fbb_pkg::rgb_t   pix_s1;
	logic            last_s1;

	// frame state
	fbb_pkg::rgb_t   bg_q;
	logic            first_pending_q;
	fbb_pkg::coord_t col_q;
	fbb_pkg::coord_t row_q;
	fbb_pkg::coord_t min_x_q;
	fbb_pkg::coord_t max_x_q;
	fbb_pkg::coord_t min_y_q;
	fbb_pkg::coord_t max_y_q;
	logic            any_fg_q;

	// result register
	logic            out_valid_q;
	logic            found_q;
	fbb_pkg::coord_t res_min_x_q;
	fbb_pkg::coord_t res_max_x_q;
	fbb_pkg::coord_t res_min_y_q;
	fbb_pkg::coord_t res_max_y_q;

	// next-state logic
	logic                        advance;
	logic                        load_res;
	fbb_pkg::rgb_t               bg;
	logic                        fg;
	logic                        any_fg_d;
	fbb_pkg::coord_t             min_x_d;
	fbb_pkg::coord_t             max_x_d;
	fbb_pkg::coord_t             min_y_d;
	fbb_pkg::coord_t             max_y_d;
	fbb_pkg::coord_t             col_d;
	fbb_pkg::coord_t             row_d;
	logic [fbb_pkg::WIDTH_W-1:0] col_inc;

	fbb_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.settings (settings)
	);

	// handshake: stage 1 drains unless its frame result cannot be placed
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || box.ready);
	assign load_res = advance && last_s1;
	assign pixel.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.ready && pixel.valid) begin
			pix_s1  <= '{red: pixel.red, green: pixel.green, blue: pixel.blue};
			last_s1 <= pixel.frame_last;
		end
	end

	// classification and box widening
	always_comb begin
		bg = first_pending_q ? pix_s1 : bg_q;
		fg = fbb_pkg::channel_differs(pix_s1.red,   bg.red,   settings.tolerance) ||
		     fbb_pkg::channel_differs(pix_s1.green, bg.green, settings.tolerance) ||
		     fbb_pkg::channel_differs(pix_s1.blue,  bg.blue,  settings.tolerance);
		any_fg_d = any_fg_q;
		min_x_d  = min_x_q;
		max_x_d  = max_x_q;
		min_y_d  = min_y_q;
		max_y_d  = max_y_q;
		if (fg) begin
			any_fg_d = 1'b1;
			if (col_q < min_x_q) min_x_d = col_q;
			if (col_q > max_x_q) max_x_d = col_q;
			if (row_q < min_y_q) min_y_d = row_q;
			if (row_q > max_y_q) max_y_d = row_q;
		end
	end

	// raster counters, row saturates at the top coordinate
	always_comb begin
		col_inc = {1'b0, col_q} + fbb_pkg::WIDTH_W'(1);
		col_d   = col_inc[fbb_pkg::COORD_W-1:0];
		row_d   = row_q;
		if (col_inc >= settings.width) begin
			col_d = '0;
			if (row_q != fbb_pkg::COORD_MAX) row_d = row_q + fbb_pkg::coord_t'(1);
		end
	end

	// frame state update, cleared after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q            <= '0;
			first_pending_q <= 1'b1;
			col_q           <= '0;
			row_q           <= '0;
			min_x_q         <= fbb_pkg::COORD_MAX;
			max_x_q         <= '0;
			min_y_q         <= fbb_pkg::COORD_MAX;
			max_y_q         <= '0;
			any_fg_q        <= 1'b0;
		end else if (load_res) begin
			bg_q            <= '0;
			first_pending_q <= 1'b1;
			col_q           <= '0;
			row_q           <= '0;
			min_x_q         <= fbb_pkg::COORD_MAX;
			max_x_q         <= '0;
			min_y_q         <= fbb_pkg::COORD_MAX;
			max_y_q         <= '0;
			any_fg_q        <= 1'b0;
		end else if (advance) begin
			bg_q            <= bg;
			first_pending_q <= 1'b0;
			col_q           <= col_d;
			row_q           <= row_d;
			min_x_q         <= min_x_d;
			max_x_q         <= max_x_d;
			min_y_q         <= min_y_d;
			max_y_q         <= max_y_d;
			any_fg_q        <= any_fg_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (box.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, empty box reads as zeros
	always_ff @(posedge clk) begin
		if (load_res) begin
			found_q     <= any_fg_d;
			res_min_x_q <= any_fg_d ? min_x_d : '0;
			res_max_x_q <= any_fg_d ? max_x_d : '0;
			res_min_y_q <= any_fg_d ? min_y_d : '0;
			res_max_y_q <= any_fg_d ? max_y_d : '0;
		end
	end

	assign box.valid = out_valid_q;
	assign box.found = found_q;
	assign box.min_x = res_min_x_q;
	assign box.max_x = res_max_x_q;
	assign box.min_y = res_min_y_q;
	assign box.max_y = res_max_y_q;

	// a frame end must wait while the previous box is still held
	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !box.ready |-> !pixel.ready)
		else $error("frame end overwrote a pending box");

	// state is back to an empty frame after a box is produced
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> first_pending_q && col_q == '0 && row_q == '0 && !any_fg_q)
		else $error("frame state not cleared after box");

	// no foreground can be recorded before a background exists
	a_bg_first: assert property (@(posedge clk) disable iff (!arst_n)
		first_pending_q |-> !any_fg_q && max_x_q == '0 && max_y_q == '0)
		else $error("box widened before background was taken");

	// an empty box carries zero coordinates
	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		box.valid && !box.found |-> box.min_x == '0 && box.max_x == '0 &&
			box.min_y == '0 && box.max_y == '0)
		else $error("empty box with non-zero coordinates");

endmodule

`default_nettype wire
